// File: hdl/srbs_pkg.sv
package srbs_pkg;

    localparam int SENSOR_COUNT_DEF = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int TIME_W           = 32;

    localparam logic [TIME_W-1:0] RESET_FIRST_WAIT    = 32'd1000;
    localparam logic [TIME_W-1:0] RESET_MAX_WAIT      = 32'd300000;
    localparam logic [TIME_W-1:0] RESET_STOPPED_AFTER = 32'd30000;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_RETRY  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOPPED_AFTER = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        sensor_index;
        logic [TIME_W-1:0] now_ms;
        logic              start_ok;
        logic              reading_due;
        logic              reading_valid;
    } in_item_t;

    typedef struct packed {
        logic              attempt_restart;
        logic              is_running;
        logic              became_stopped;
        logic [TIME_W-1:0] restart_total;
    } out_item_t;

    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] last_reading;
        logic [TIME_W-1:0] retry_time;
        logic [TIME_W-1:0] retry_wait;
    } sensor_rec_t;

    localparam sensor_rec_t RESET_REC = '{
        running:      1'b0,
        last_reading: '0,
        retry_time:   '0,
        retry_wait:   RESET_FIRST_WAIT
    };

endpackage

// File: hdl/srbs_ram.sv
module srbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sensor_restart_backoff_supervisor.sv
// Each input beat is accepted only while no item is being worked on; its record is
// read from the record memory through a registered read, then updated and written back
// as the result is registered; a stalled output holds the write-back and in_ready low.
// Reset: rst_n clears the per-entry valid bits, the restart counter, the handshake
// flags and loads the register reset values; entries never written read as the
// reset record, so no clearing pass runs.
module sensor_restart_backoff_supervisor #(
    parameter int SENSOR_COUNT = srbs_pkg::SENSOR_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  srbs_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output srbs_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [srbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srbs_pkg::TIME_W-1:0]    cfg_data
);

    import srbs_pkg::*;

    localparam int AW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int REC_W = $bits(sensor_rec_t);

    logic                    busy_reg, busy_next;
    in_item_t                item_reg;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg;
    logic [TIME_W-1:0]       restart_cnt_reg, restart_cnt_next;
    logic [TIME_W-1:0]       first_wait_reg, max_wait_reg, stop_after_reg;
    logic [SENSOR_COUNT-1:0] valid_reg, valid_next;

    logic              accept, done, in_range, rec_we;
    logic [AW-1:0]     addr_q;
    logic [REC_W-1:0]  rdata;
    sensor_rec_t       rec, rec_new;
    out_item_t         result;
    logic [TIME_W-1:0] since_retry, since_reading;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign done     = busy_reg && (!out_valid_reg || out_ready);
    assign addr_q   = AW'(item_reg.sensor_index);
    assign in_range = (32'(item_reg.sensor_index) < SENSOR_COUNT);
    assign rec_we   = done && in_range;

    srbs_ram #(
        .WIDTH (REC_W),
        .DEPTH (SENSOR_COUNT),
        .ADDR_W(AW)
    ) u_rec_ram (
        .clk  (clk),
        .we   (rec_we),
        .waddr(addr_q),
        .wdata(rec_new),
        .re   (accept),
        .raddr(AW'(in_data.sensor_index)),
        .rdata(rdata)
    );

    // never-written entries read as the reset record
    assign rec           = valid_reg[addr_q] ? sensor_rec_t'(rdata) : RESET_REC;
    assign since_retry   = item_reg.now_ms - rec.retry_time;
    assign since_reading = item_reg.now_ms - rec.last_reading;

    always_comb
    begin
        rec_new          = rec;
        restart_cnt_next = restart_cnt_reg;
        result           = '0;
        unique case (item_reg.kind)
            KIND_START:
            begin
                rec_new.running      = item_reg.start_ok;
                rec_new.last_reading = item_reg.now_ms;
                if (item_reg.start_ok)
                begin
                    rec_new.retry_wait = first_wait_reg;
                end
                else
                begin
                    rec_new.retry_time = item_reg.now_ms + rec.retry_wait;
                    rec_new.retry_wait = (rec.retry_wait > (max_wait_reg >> 1))
                                       ? max_wait_reg
                                       : {rec.retry_wait[TIME_W-2:0], 1'b0};
                end
            end
            KIND_RETRY:
            begin
                if (!rec.running && !since_retry[TIME_W-1] && in_range)
                begin
                    result.attempt_restart = 1'b1;
                    restart_cnt_next       = restart_cnt_reg + 32'd1;
                end
            end
            KIND_SAMPLE:
            begin
                if (rec.running)
                begin
                    if (item_reg.reading_valid)
                    begin
                        rec_new.last_reading = item_reg.now_ms;
                    end
                    else if (item_reg.reading_due && (since_reading >= stop_after_reg))
                    begin
                        rec_new.running       = 1'b0;
                        rec_new.retry_time    = item_reg.now_ms;
                        rec_new.retry_wait    = first_wait_reg;
                        result.became_stopped = in_range;
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.is_running    = in_range && rec_new.running;
        result.restart_total = restart_cnt_next;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        valid_next     = valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (rec_we)
        begin
            valid_next[addr_q] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            valid_reg       <= '0;
            restart_cnt_reg <= '0;
            first_wait_reg  <= RESET_FIRST_WAIT;
            max_wait_reg    <= RESET_MAX_WAIT;
            stop_after_reg  <= RESET_STOPPED_AFTER;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (done)
            begin
                restart_cnt_reg <= restart_cnt_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIRST_WAIT:    first_wait_reg <= cfg_data;
                    CFG_MAX_WAIT:      max_wait_reg   <= cfg_data;
                    CFG_STOPPED_AFTER: stop_after_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers: hold the beat being worked on and the finished result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (done)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted beat did not start work");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy_reg && out_valid_reg))
        else $error("finished item did not reach the output register");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.attempt_restart) |=> (restart_cnt_reg == $past(restart_cnt_reg) + 32'd1))
        else $error("restart counter did not advance on a restart request");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(restart_cnt_reg))
        else $error("restart counter moved outside a write-back");

    a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.became_stopped && out_data_reg.is_running))
        else $error("sensor reported stopped and running at once");
`endif

endmodule

// File: verif/srbs_checker.sv
`timescale 1ns / 100ps

module srbs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  srbs_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  srbs_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [srbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srbs_pkg::TIME_W-1:0]    cfg_data,
    output int                             mismatch_count,
    output int                             outcome_count,
    output int                             waiting_count
);
    import srbs_pkg::*;

    localparam int NSENS = SENSOR_COUNT_DEF;

    // shadow of the configuration registers
    logic [TIME_W-1:0] first_wait;
    logic [TIME_W-1:0] max_wait;
    logic [TIME_W-1:0] stop_after;

    // shadow of the sensor table
    logic              run_flag  [NSENS];
    logic [TIME_W-1:0] last_seen [NSENS];
    logic [TIME_W-1:0] retry_at  [NSENS];
    logic [TIME_W-1:0] wait_ms   [NSENS];
    logic [TIME_W-1:0] restarts;

    out_item_t outcome_q [$];

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got_v,
                                   input logic [TIME_W-1:0] want_v);
        mismatch_count = mismatch_count + 1;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
    endtask

    task automatic predict_outcome(input in_item_t it, output out_item_t res);
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] diff;
        int unsigned       s;
        res = '0;
        s   = 32'(it.sensor_index);
        case (it.kind)
            KIND_START:
            begin
                run_flag[s]  = it.start_ok;
                last_seen[s] = it.now_ms;
                if (it.start_ok)
                begin
                    wait_ms[s] = first_wait;
                end
                else
                begin
                    w           = wait_ms[s];
                    retry_at[s] = it.now_ms + w;
                    // double the wait, saturate at the ceiling
                    wait_ms[s]  = (w > (max_wait >> 1)) ? max_wait : (w << 1);
                end
            end
            KIND_RETRY:
            begin
                diff = it.now_ms - retry_at[s];
                if (!run_flag[s] && !diff[TIME_W-1])
                begin
                    restarts            = restarts + 1;
                    res.attempt_restart = 1'b1;
                end
            end
            KIND_SAMPLE:
            begin
                diff = it.now_ms - last_seen[s];
                if (run_flag[s])
                begin
                    if (it.reading_valid)
                    begin
                        last_seen[s] = it.now_ms;
                    end
                    else if (it.reading_due && diff >= stop_after)
                    begin
                        run_flag[s]        = 1'b0;
                        retry_at[s]        = it.now_ms;
                        wait_ms[s]         = first_wait;
                        res.became_stopped = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.is_running    = run_flag[s];
        res.restart_total = restarts;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            first_wait = RESET_FIRST_WAIT;
            max_wait   = RESET_MAX_WAIT;
            stop_after = RESET_STOPPED_AFTER;
            for (int i = 0; i < NSENS; i++)
            begin
                run_flag[i]  = 1'b0;
                last_seen[i] = '0;
                retry_at[i]  = '0;
                wait_ms[i]   = RESET_FIRST_WAIT;
            end
            restarts       = '0;
            mismatch_count = 0;
            outcome_q.delete();
            outcome_count <= 0;
            waiting_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_WAIT:    first_wait = cfg_data;
                    CFG_MAX_WAIT:      max_wait   = cfg_data;
                    CFG_STOPPED_AFTER: stop_after = cfg_data;
                    default: ;
                endcase
            end
            // check the result beat before queuing a new expectation
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (outcome_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", got.restart_total, '0);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.attempt_restart !== want.attempt_restart)
                        report_mismatch("attempt_restart", TIME_W'(got.attempt_restart),
                                        TIME_W'(want.attempt_restart));
                    if (got.is_running !== want.is_running)
                        report_mismatch("is_running", TIME_W'(got.is_running),
                                        TIME_W'(want.is_running));
                    if (got.became_stopped !== want.became_stopped)
                        report_mismatch("became_stopped", TIME_W'(got.became_stopped),
                                        TIME_W'(want.became_stopped));
                    if (got.restart_total !== want.restart_total)
                        report_mismatch("restart_total", got.restart_total,
                                        want.restart_total);
                end
                outcome_count <= outcome_count + 1;
            end
            if (in_valid && in_ready)
            begin
                predict_outcome(in_data, want);
                outcome_q.push_back(want);
            end
            waiting_count <= outcome_q.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import srbs_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         GAP_MAX         = 13;
    localparam int         NSENS           = SENSOR_COUNT_DEF;
    localparam int         PHASES          = 12;
    localparam int         ITEMS_PER_PHASE = 160;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;
    in_item_t             in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    out_item_t            out_data;

    int mismatch_count;
    int outcome_count;
    int waiting_count;
    int beats_sent  = 0;
    int phases_run  = 0;
    int in_gap_max  = GAP_MAX;
    int out_gap_max = GAP_MAX;

    // register values currently loaded, used to aim times at thresholds
    logic [TIME_W-1:0] first_w = RESET_FIRST_WAIT;
    logic [TIME_W-1:0] max_w   = RESET_MAX_WAIT;
    logic [TIME_W-1:0] stop_w  = RESET_STOPPED_AFTER;

    // rough per-sensor anchors for stimulus shaping
    logic [TIME_W-1:0] seen_at   [NSENS];
    logic [TIME_W-1:0] failed_at [NSENS];

    always #4 clk = ~clk;

    sensor_restart_backoff_supervisor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srbs_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outcome_count  (outcome_count),
        .waiting_count  (waiting_count)
    );

    function automatic in_item_t pack_item(input logic [1:0] kind, input logic [1:0] idx,
                                           input logic [TIME_W-1:0] now, input logic ok,
                                           input logic due, input logic valid);
        in_item_t it;
        it.kind          = kind;
        it.sensor_index  = idx;
        it.now_ms        = now;
        it.start_ok      = ok;
        it.reading_due   = due;
        it.reading_valid = valid;
        return it;
    endfunction

    task automatic send_beat(input in_item_t it);
        int n;
        n = $urandom_range(0, in_gap_max);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // drop valid and wait until every beat sent has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_count < beats_sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [TIME_W-1:0] first_v,
                                 input logic [TIME_W-1:0] max_v,
                                 input logic [TIME_W-1:0] stop_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_WAIT;
        cfg_data  <= first_v;
        @(posedge clk);
        cfg_index <= CFG_MAX_WAIT;
        cfg_data  <= max_v;
        @(posedge clk);
        cfg_index <= CFG_STOPPED_AFTER;
        cfg_data  <= stop_v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        first_w = first_v;
        max_w   = max_v;
        stop_w  = stop_v;
    endtask

    task automatic build_item(output in_item_t it);
        int unsigned       s;
        int unsigned       pick;
        logic [TIME_W-1:0] off;
        it   = '0;
        s    = $urandom_range(0, NSENS - 1);
        off  = $urandom_range(0, 4);
        off  = off - 2;
        pick = $urandom_range(0, 99);
        it.sensor_index = s[1:0];
        if (pick < 12)
        begin
            // noise: any field value, unused kind included
            it.kind          = 2'($urandom_range(0, 3));
            it.now_ms        = $urandom;
            it.start_ok      = 1'($urandom_range(0, 1));
            it.reading_due   = 1'($urandom_range(0, 1));
            it.reading_valid = 1'($urandom_range(0, 1));
        end
        else if (pick < 42)
        begin
            it.kind     = KIND_START;
            it.start_ok = ($urandom_range(0, 99) < 40);
            it.now_ms   = seen_at[s] + $urandom_range(0, 40);
            seen_at[s]  = it.now_ms;
            if (!it.start_ok)
                failed_at[s] = it.now_ms;
        end
        else if (pick < 67)
        begin
            it.kind = KIND_RETRY;
            case ($urandom_range(0, 2))
                0:       it.now_ms = failed_at[s] + (first_w << $urandom_range(0, 9)) + off;
                1:       it.now_ms = failed_at[s] + max_w + off;
                default: it.now_ms = seen_at[s] + $urandom_range(0, 60);
            endcase
        end
        else
        begin
            it.kind          = KIND_SAMPLE;
            it.reading_valid = ($urandom_range(0, 99) < 35);
            it.reading_due   = ($urandom_range(0, 99) < 85);
            if ($urandom_range(0, 1))
                it.now_ms = seen_at[s] + stop_w + off;
            else
                it.now_ms = seen_at[s] + $urandom_range(0, 30);
            if (it.reading_valid)
                seen_at[s] = it.now_ms;
        end
    endtask

    initial
    begin : result_sink
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = $urandom_range(0, out_gap_max);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        in_item_t          it;
        logic [TIME_W-1:0] base;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stopped sample, retry sign boundary, wrap, stop detection
        send_beat(pack_item(KIND_SAMPLE, 2'd0, 32'd0, 1'b0, 1'b1, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd1, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd2, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_START, 2'd0, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd0, 32'hFFFF_FF00 + 32'd999, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd0, 32'hFFFF_FF00 + 32'd1000, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_START, 2'd1, 32'd100, 1'b1, 1'b0, 1'b0));
        send_beat(pack_item(KIND_SAMPLE, 2'd1, 32'd200, 1'b0, 1'b1, 1'b1));
        send_beat(pack_item(KIND_SAMPLE, 2'd1, 32'd30199, 1'b0, 1'b1, 1'b0));
        send_beat(pack_item(KIND_SAMPLE, 2'd1, 32'd30200, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_SAMPLE, 2'd1, 32'd30200, 1'b0, 1'b1, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd1, 32'd30200, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_UNUSED, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        send_beat(pack_item(KIND_START, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
        send_beat(pack_item(KIND_SAMPLE, 2'd3, 32'd0, 1'b0, 1'b1, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd3, 32'd0, 1'b0, 1'b0, 1'b0));
        settle();

        // doubling hits the ceiling exactly, then stays saturated
        load_settings(32'd5, 32'd10, 32'd5);
        send_beat(pack_item(KIND_START, 2'd2, 32'd10, 1'b1, 1'b0, 1'b0));
        send_beat(pack_item(KIND_START, 2'd2, 32'd20, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd2, 32'd24, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_RETRY, 2'd2, 32'd25, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_START, 2'd2, 32'd30, 1'b0, 1'b0, 1'b0));
        send_beat(pack_item(KIND_START, 2'd2, 32'd40, 1'b0, 1'b0, 1'b0));
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       load_settings(32'd1, 32'd1, 32'd1);
                1:       load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2:       load_settings(32'd0, 32'd0, 32'd0);
                3:       load_settings(RESET_FIRST_WAIT, RESET_MAX_WAIT, RESET_STOPPED_AFTER);
                4:       load_settings(32'd1, 32'hFFFF_FFFF, 32'd7);
                5:       load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
                6:       load_settings($urandom, $urandom, $urandom);
                default: load_settings($urandom_range(1, 20), $urandom_range(1, 400),
                                       $urandom_range(1, 60));
            endcase
            // vary backpressure per phase, some phases with none at all
            case (p % 4)
                0:
                begin
                    in_gap_max  = GAP_MAX;
                    out_gap_max = GAP_MAX;
                end
                1:
                begin
                    in_gap_max  = 0;
                    out_gap_max = 0;
                end
                2:
                begin
                    in_gap_max  = GAP_MAX;
                    out_gap_max = 0;
                end
                default:
                begin
                    in_gap_max  = 0;
                    out_gap_max = GAP_MAX;
                end
            endcase
            base = ($urandom_range(0, 2) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 500))
                                               : $urandom;
            for (int i = 0; i < NSENS; i++)
            begin
                seen_at[i]   = base;
                failed_at[i] = base;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                build_item(it);
                send_beat(it);
            end
            settle();
            phases_run++;
        end

        $display("Sent %0d beats over %0d random register settings plus directed cases.",
                 beats_sent, phases_run);
        $display("Checked %0d results: start, retry, sample and unused kinds, %s",
                 outcome_count, "backoff saturation, stop detection and time wrap.");
        if (mismatch_count == 0 && waiting_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
